// ----- rtl/core/tcgr_pkg.sv -----
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared widths, request codes and fixed constants of the text console
// glyph renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcgr_pkg;

    // field widths of the request and result transfers
    localparam int REQ_W     = 2;
    localparam int CODE_W    = 8;
    localparam int GROW_W    = 4;
    localparam int BITS_W    = 8;
    localparam int PIX_Y_W   = 9;
    localparam int PIX_X_W   = 10;

    // cursor register widths
    localparam int COL_W     = 7;
    localparam int LINE_W    = 5;

    // glyph cells are always eight pixels wide
    localparam int GLYPH_WIDTH = 8;
    localparam int X_SHIFT     = $clog2(GLYPH_WIDTH);

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BACK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_BLINK = 2'd2;
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd3;

    // special characters and glyphs
    localparam logic [CODE_W-1:0] CURSOR_GLYPH = 8'd22;
    localparam logic [CODE_W-1:0] BLANK_GLYPH  = 8'd0;
    localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [COL_W-1:0]  BACK_MIN_COL = 7'd2;

endpackage

`default_nettype wire

// ----- rtl/core/text_console_glyph_renderer_unit.sv -----
// The first glyph row of a request passes the sequencer, read stage and output register.
// One result per cycle while out_stall is low; a request holds the sequencer while it issues
// its results and the next request is taken once the sequencer is back in idle; a put
// character that wraps the screen issues the most results, and a font load issues none.
// The rate is set by the single read port of the font store, one glyph row a cycle unless stalled.
// Reset clears the cursor, shows the cursor glyph on the next blink; the font store is not cleared.
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_unit
// Text console: font store in a synchronous memory, a row sequencer that
// reads one glyph row per cycle unless stalled, and a read stage plus output register.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_glyph_renderer_unit #(
    parameter int TEXT_COLUMNS = 80,
    parameter int TEXT_ROWS    = 24,
    parameter int GLYPH_HEIGHT = 12
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [tcgr_pkg::REQ_W-1:0]    req_type,
    input  wire logic [tcgr_pkg::CODE_W-1:0]   char_code,
    input  wire logic [tcgr_pkg::GROW_W-1:0]   glyph_row,
    input  wire logic [tcgr_pkg::BITS_W-1:0]   glyph_bits,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [tcgr_pkg::PIX_Y_W-1:0]       pixel_y,
    output logic [tcgr_pkg::PIX_X_W-1:0]       pixel_x,
    output logic [tcgr_pkg::BITS_W-1:0]        row_bits,
    output logic                               clear_screen,
    output logic                               last_result
);

    import tcgr_pkg::*;

    localparam int STORE_DEPTH = 256 * GLYPH_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ROW_W       = $clog2(GLYPH_HEIGHT);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DRAW  = 2'd1;
    localparam logic [1:0] ST_CLEAR = 2'd2;

    // sequencer and cursor state
    logic [1:0]        state_reg, state_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CODE_W-1:0] glyph_reg, glyph_next;
    logic [COL_W-1:0]  draw_col_reg, draw_col_next;
    logic [LINE_W-1:0] draw_line_reg, draw_line_next;
    logic              b_pend_reg, b_pend_next;
    logic [COL_W-1:0]  b_col_reg, b_col_next;
    logic              clr_pend_reg, clr_pend_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic              phase_reg, phase_next;

    // read stage and output register
    logic                s1_valid_reg;
    logic [PIX_Y_W-1:0]  s1_y_reg;
    logic [PIX_X_W-1:0]  s1_x_reg;
    logic                s1_clr_reg;
    logic                s1_last_reg;
    logic [BITS_W-1:0]   rd_data_reg;
    logic                out_valid_reg;
    logic [PIX_Y_W-1:0]  pixel_y_reg;
    logic [PIX_X_W-1:0]  pixel_x_reg;
    logic [BITS_W-1:0]   row_bits_reg;
    logic                clear_reg;
    logic                last_reg;

    // font store
    logic [BITS_W-1:0] glyph_mem [STORE_DEPTH];

    logic              in_xfer;
    logic              out_free;
    logic              advance;
    logic              slot_valid;
    logic              slot_clr;
    logic              slot_last;
    logic              row_last;
    logic [PIX_Y_W-1:0] slot_y;
    logic [PIX_X_W-1:0] slot_x;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;
    logic [COL_W-1:0]  col_inc;
    logic [LINE_W-1:0] line_inc;
    logic              newline;

    // handshakes
    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = !s1_valid_reg || out_free;

    // current slot of the sequencer
    assign slot_valid = (state_reg != ST_IDLE);
    assign slot_clr   = (state_reg == ST_CLEAR);
    assign row_last   = (32'(row_reg) == GLYPH_HEIGHT - 1);
    assign slot_last  = slot_clr || (row_last && !b_pend_reg && !clr_pend_reg);
    assign slot_y     = slot_clr ? '0
                      : PIX_Y_W'(32'(draw_line_reg) * GLYPH_HEIGHT + 32'(row_reg));
    assign slot_x     = slot_clr ? '0 : (PIX_X_W'(draw_col_reg) << X_SHIFT);
    assign rd_addr    = ADDR_W'(32'(glyph_reg) * GLYPH_HEIGHT + 32'(row_reg));
    assign rd_en      = slot_valid && advance && !slot_clr;

    // font row load
    assign wr_addr = ADDR_W'(32'(char_code) * GLYPH_HEIGHT + 32'(glyph_row));
    assign wr_en   = in_xfer && (req_type == REQ_LOAD) && (32'(glyph_row) < GLYPH_HEIGHT);

    // cursor arithmetic for a put character
    assign col_inc  = col_reg + 1'b1;
    assign line_inc = line_reg + 1'b1;
    assign newline  = (32'(col_inc) >= TEXT_COLUMNS) || (char_code == NEWLINE_CODE);

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        glyph_next     = glyph_reg;
        draw_col_next  = draw_col_reg;
        draw_line_next = draw_line_reg;
        b_pend_next    = b_pend_reg;
        b_col_next     = b_col_reg;
        clr_pend_next  = clr_pend_reg;
        col_next       = col_reg;
        line_next      = line_reg;
        phase_next     = phase_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    row_next       = '0;
                    draw_col_next  = col_reg;
                    draw_line_next = line_reg;
                    clr_pend_next  = 1'b0;
                    b_pend_next    = 1'b0;
                    unique case (req_type)
                        REQ_PUT:
                        begin
                            state_next    = ST_DRAW;
                            glyph_next    = char_code;
                            b_pend_next   = newline;
                            b_col_next    = col_inc;
                            clr_pend_next = newline && (32'(line_inc) >= TEXT_ROWS);
                            if (newline)
                            begin
                                col_next  = '0;
                                line_next = (32'(line_inc) >= TEXT_ROWS) ? '0 : line_inc;
                            end
                            else
                            begin
                                col_next  = col_inc;
                            end
                        end
                        REQ_BACK:
                        begin
                            if (col_reg > BACK_MIN_COL)
                            begin
                                state_next  = ST_DRAW;
                                glyph_next  = BLANK_GLYPH;
                                b_pend_next = 1'b1;
                                b_col_next  = col_reg - 1'b1;
                                col_next    = col_reg - 1'b1;
                            end
                        end
                        REQ_BLINK:
                        begin
                            state_next = ST_DRAW;
                            glyph_next = phase_reg ? CURSOR_GLYPH : BLANK_GLYPH;
                            phase_next = !phase_reg;
                        end
                        REQ_LOAD:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DRAW:
            begin
                if (advance)
                begin
                    if (!row_last)
                    begin
                        row_next = row_reg + 1'b1;
                    end
                    else if (b_pend_reg)
                    begin
                        row_next      = '0;
                        glyph_next    = BLANK_GLYPH;
                        draw_col_next = b_col_reg;
                        b_pend_next   = 1'b0;
                    end
                    else if (clr_pend_reg)
                    begin
                        state_next    = ST_CLEAR;
                        clr_pend_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CLEAR:
            begin
                if (advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            b_pend_reg    <= 1'b0;
            clr_pend_reg  <= 1'b0;
            col_reg       <= '0;
            line_reg      <= '0;
            phase_reg     <= 1'b1;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            b_pend_reg   <= b_pend_next;
            clr_pend_reg <= clr_pend_next;
            col_reg      <= col_next;
            line_reg     <= line_next;
            phase_reg    <= phase_next;
            if (advance)
            begin
                s1_valid_reg <= slot_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // sequencer payload
    always_ff @(posedge clk)
    begin
        glyph_reg     <= glyph_next;
        draw_col_reg  <= draw_col_next;
        draw_line_reg <= draw_line_next;
        b_col_reg     <= b_col_next;
    end

    // read stage payload
    always_ff @(posedge clk)
    begin
        if (advance && slot_valid)
        begin
            s1_y_reg    <= slot_y;
            s1_x_reg    <= slot_x;
            s1_clr_reg  <= slot_clr;
            s1_last_reg <= slot_last;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            pixel_y_reg  <= s1_y_reg;
            pixel_x_reg  <= s1_x_reg;
            row_bits_reg <= s1_clr_reg ? '0 : rd_data_reg;
            clear_reg    <= s1_clr_reg;
            last_reg     <= s1_last_reg;
        end
    end

    // font store write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            glyph_mem[wr_addr] <= glyph_bits;
        end
    end

    // font store read port, data held while the read stage waits
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= glyph_mem[rd_addr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_y      = pixel_y_reg;
    assign pixel_x      = pixel_x_reg;
    assign row_bits     = row_bits_reg;
    assign clear_screen = clear_reg;
    assign last_result  = last_reg;

    // cursor stays on the text grid
    assert property (@(posedge clk) disable iff (!rst_n)
        (32'(col_reg) < TEXT_COLUMNS) && (32'(line_reg) < TEXT_ROWS))
        else $error("cursor left the text grid");

    // a clear-screen result is always the final one and carries no position
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && clear_reg |-> last_reg && (pixel_x_reg == '0) && (pixel_y_reg == '0))
        else $error("malformed clear-screen result");

    // drawn cells never start beyond one past the last column
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (32'(pixel_x_reg) <= TEXT_COLUMNS * GLYPH_WIDTH))
        else $error("pixel column out of range");

    // read data held while the read stage is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(rd_data_reg))
        else $error("read stage lost its data under stall");

    // no second cell is pending once the clear result is being issued
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !b_pend_reg && !clr_pend_reg)
        else $error("clear issued with drawing still pending");

endmodule

`default_nettype wire
